### hdl/lrc_pkg.sv
package lrc_pkg;

  // Fixed widths of the register file and the colour path
  localparam int unsigned DimBits    = 13;
  localparam int unsigned ColourBits = 8;
  localparam int unsigned ApbAddrBits = 4;
  localparam int unsigned ApbDataBits = 32;

  // Register indexes, taken from paddr[3:2]
  localparam logic [1:0] RegFrameWidth  = 2'd0;
  localparam logic [1:0] RegFrameHeight = 2'd1;
  localparam logic [1:0] RegDrawColour  = 2'd2;

  // Reset values of the registers
  localparam logic [DimBits-1:0]    FrameWidthRst  = 13'd640;
  localparam logic [DimBits-1:0]    FrameHeightRst = 13'd480;
  localparam logic [ColourBits-1:0] DrawColourRst  = 8'd255;

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } opcode_e;

  typedef struct packed {
    logic [DimBits-1:0]    frame_width;
    logic [DimBits-1:0]    frame_height;
    logic [ColourBits-1:0] draw_colour;
  } cfg_t;

endpackage

### hdl/lrc_fifo.sv
module lrc_fifo #(
  parameter int unsigned WIDTH = 56,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PtrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntBits = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]   mem_q [DEPTH];
  logic [PtrBits-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrBits-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntBits-1:0] count_q, count_d;
  logic               do_push, do_pop;

  assign full_o  = (count_q == CntBits'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrBits'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrBits'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntBits'(DEPTH))
    else $error("queue count above depth");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> !empty_o)
    else $error("queue empty after a lone push");

  a_pop_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_pop && !do_push) |=> !full_o)
    else $error("queue full after a lone pop");

endmodule

### hdl/lrc_front.sv
module lrc_front #(
  parameter int unsigned COORD_BITS = 13
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  lrc_pkg::opcode_e          opcode_i,
  input  logic [COORD_BITS-1:0]     start_x_i,
  input  logic [COORD_BITS-1:0]     start_y_i,
  input  logic [COORD_BITS-1:0]     end_x_i,
  input  logic [COORD_BITS-1:0]     end_y_i,
  output logic                      push_o,
  output logic [4*COORD_BITS+3:0]   entry_o,
  input  logic                      full_i
);

  localparam int unsigned CB = COORD_BITS;

  logic                    pv_q;
  lrc_pkg::opcode_e        op_q;
  logic [CB-1:0]           x1_q, y1_q;
  logic signed [CB:0]      dx_q, dy_q;
  logic signed [CB:0]      dx_d, dy_d;
  logic [CB:0]             adx_w, ady_w;
  logic [CB-1:0]           adx, ady, major, minor;
  logic                    steep;

  // Differences in one extra bit so no endpoint pair overflows
  assign dx_d = $signed({end_x_i[CB-1], end_x_i}) - $signed({start_x_i[CB-1], start_x_i});
  assign dy_d = $signed({end_y_i[CB-1], end_y_i}) - $signed({start_y_i[CB-1], start_y_i});

  assign push_o     = pv_q && !full_i;
  assign in_ready_o = !pv_q || !full_i;

  assign adx_w = dx_q[CB] ? -dx_q : dx_q;
  assign ady_w = dy_q[CB] ? -dy_q : dy_q;
  assign adx   = adx_w[CB-1:0];
  assign ady   = ady_w[CB-1:0];
  assign steep = ady > adx;
  assign major = steep ? ady : adx;
  assign minor = steep ? adx : ady;

  // Entry layout, low to high: minor, major, y1, x1, yneg, xneg, swap, opcode
  assign entry_o = {op_q, steep, dx_q[CB], dy_q[CB], x1_q, y1_q, major, minor};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else if (in_ready_o) begin
      pv_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      op_q <= opcode_i;
      x1_q <= start_x_i;
      y1_q <= start_y_i;
      dx_q <= dx_d;
      dy_q <= dy_d;
    end
  end

endmodule

### hdl/lrc_back.sv
module lrc_back #(
  parameter int unsigned COORD_BITS = 13
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  lrc_pkg::cfg_t                    cfg_i,
  input  logic [4*COORD_BITS+3:0]          entry_i,
  input  logic                             empty_i,
  output logic                             pop_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [COORD_BITS-1:0]            pixel_x_o,
  output logic [COORD_BITS-1:0]            pixel_y_o,
  output logic                             inside_o,
  output logic [lrc_pkg::ColourBits-1:0]   colour_o,
  output logic                             last_o
);

  localparam int unsigned CB       = COORD_BITS;
  localparam int unsigned ErrBits  = CB + 3;
  localparam int unsigned CmpBits  = (CB > lrc_pkg::DimBits) ? CB : lrc_pkg::DimBits;

  logic [CB-1:0]              e_minor, e_major, e_x1, e_y1;
  logic                       e_yneg, e_xneg, e_swap;
  lrc_pkg::opcode_e           e_op;

  logic [CB-1:0]              cur_x_q, cur_y_q, major_q, pl_q;
  logic                       xneg_q, yneg_q, swap_q;
  logic signed [ErrBits-1:0]  err_q, up_q, dn_q;
  logic signed [ErrBits-1:0]  ld_up, ld_dn, ld_err;
  logic                       out_free, is_start, emit, err_ge, x_en, y_en, in_frame;

  assign e_minor = entry_i[CB-1:0];
  assign e_major = entry_i[2*CB-1:CB];
  assign e_y1    = entry_i[3*CB-1:2*CB];
  assign e_x1    = entry_i[4*CB-1:3*CB];
  assign e_yneg  = entry_i[4*CB];
  assign e_xneg  = entry_i[4*CB+1];
  assign e_swap  = entry_i[4*CB+2];
  assign e_op    = lrc_pkg::opcode_e'(entry_i[4*CB+3]);

  assign out_free = !out_valid_o || out_ready_i;
  assign is_start = (e_op == lrc_pkg::OP_START);
  assign pop_o    = !empty_i && (is_start || out_free);
  assign emit     = pop_o && !is_start && (pl_q != '0);

  // Error increments: 2*minor when no minor step, 2*minor-2*major otherwise
  assign ld_up  = $signed(ErrBits'({e_minor, 1'b0}));
  assign ld_dn  = ld_up - $signed(ErrBits'({e_major, 1'b0}));
  assign ld_err = ld_up - $signed(ErrBits'(e_major));

  assign err_ge = !err_q[ErrBits-1];
  assign x_en   = swap_q ? err_ge : 1'b1;
  assign y_en   = swap_q ? 1'b1 : err_ge;

  assign in_frame = !cur_x_q[CB-1] && (CmpBits'(cur_x_q) < CmpBits'(cfg_i.frame_width)) &&
                    !cur_y_q[CB-1] && (CmpBits'(cur_y_q) < CmpBits'(cfg_i.frame_height));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pl_q        <= '0;
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      major_q     <= '0;
      err_q       <= '0;
      up_q        <= '0;
      dn_q        <= '0;
      xneg_q      <= 1'b0;
      yneg_q      <= 1'b0;
      swap_q      <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      if (pop_o && is_start) begin
        cur_x_q <= e_x1;
        cur_y_q <= e_y1;
        major_q <= e_major;
        pl_q    <= e_major;
        err_q   <= ld_err;
        up_q    <= ld_up;
        dn_q    <= ld_dn;
        xneg_q  <= e_xneg;
        yneg_q  <= e_yneg;
        swap_q  <= e_swap;
      end else if (emit) begin
        if (x_en) begin
          cur_x_q <= xneg_q ? cur_x_q - 1'b1 : cur_x_q + 1'b1;
        end
        if (y_en) begin
          cur_y_q <= yneg_q ? cur_y_q - 1'b1 : cur_y_q + 1'b1;
        end
        err_q <= err_q + (err_ge ? dn_q : up_q);
        pl_q  <= pl_q - 1'b1;
      end
      if (emit) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      pixel_x_o <= cur_x_q;
      pixel_y_o <= cur_y_q;
      inside_o  <= in_frame;
      colour_o  <= cfg_i.draw_colour;
      last_o    <= (pl_q == CB'(1));
    end
  end

  a_last_ends_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && pl_q == CB'(1)) |=> (pl_q == '0))
    else $error("line still active after its last pixel");

  a_count_in_major: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pl_q <= major_q)
    else $error("remaining pixel count exceeds major delta");

  a_err_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pl_q != '0) |-> (err_q >= dn_q && err_q < up_q))
    else $error("error term left its window");

  a_no_emit_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pl_q == '0 && !(pop_o && is_start)) |=> !$rose(out_valid_o))
    else $error("pixel emitted with no line active");

endmodule

### hdl/line_raster_clipped.sv
// Path: a step's pixel crosses the input stage, command queue and output register.
// Throughput: one command per cycle while the queue has room; each pixel update is
//   a single error add and two coordinate steps, so one pixel leaves per cycle while
//   m_axis_tready stays high.
// Reset (rst_ni, asynchronous, active low): no line active, queue empty, registers
//   at frame_width 640, frame_height 480, draw_colour 255.
module line_raster_clipped #(
  parameter int unsigned COORD_BITS = 13
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // Command stream
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // tdata, low to high: start_x, start_y, end_x, end_y, zero fill
  input  logic [((4*COORD_BITS+7)/8)*8-1:0]      s_axis_tdata,
  // tuser: opcode (0 start, 1 step)
  input  logic                                   s_axis_tuser,
  // Pixel stream
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // tdata, low to high: pixel_x, pixel_y, colour, zero fill
  output logic [((2*COORD_BITS+8+7)/8)*8-1:0]    m_axis_tdata,
  // tuser: inside_res
  output logic                                   m_axis_tuser,
  output logic                                   m_axis_tlast,
  // Register port
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [lrc_pkg::ApbAddrBits-1:0]        paddr,
  input  logic [lrc_pkg::ApbDataBits-1:0]        pwdata,
  output logic [lrc_pkg::ApbDataBits-1:0]        prdata,
  output logic                                   pready
);

  localparam int unsigned CB        = COORD_BITS;
  localparam int unsigned STdataW   = ((4*CB+7)/8)*8;
  localparam int unsigned MPayloadW = 2*CB + lrc_pkg::ColourBits;
  localparam int unsigned MTdataW   = ((MPayloadW+7)/8)*8;
  localparam int unsigned EntryW    = 4*CB + 4;
  localparam int unsigned QueueDepth = 2;

  lrc_pkg::cfg_t       cfg_q;
  logic                cfg_wr;
  logic [1:0]          reg_idx;

  logic                push, full, pop, empty;
  logic [EntryW-1:0]   wr_entry, rd_entry;

  logic [CB-1:0]       pixel_x, pixel_y;
  logic [lrc_pkg::ColourBits-1:0] colour;

  // ---------------------------------------------------------------------------
  // Register file: a write lands on the access cycle of the transaction.
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width  <= lrc_pkg::FrameWidthRst;
      cfg_q.frame_height <= lrc_pkg::FrameHeightRst;
      cfg_q.draw_colour  <= lrc_pkg::DrawColourRst;
    end else if (cfg_wr) begin
      case (reg_idx)
        lrc_pkg::RegFrameWidth:  cfg_q.frame_width  <= pwdata[lrc_pkg::DimBits-1:0];
        lrc_pkg::RegFrameHeight: cfg_q.frame_height <= pwdata[lrc_pkg::DimBits-1:0];
        lrc_pkg::RegDrawColour:  cfg_q.draw_colour  <= pwdata[lrc_pkg::ColourBits-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      lrc_pkg::RegFrameWidth:  prdata = lrc_pkg::ApbDataBits'(cfg_q.frame_width);
      lrc_pkg::RegFrameHeight: prdata = lrc_pkg::ApbDataBits'(cfg_q.frame_height);
      lrc_pkg::RegDrawColour:  prdata = lrc_pkg::ApbDataBits'(cfg_q.draw_colour);
      default:                 prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Front end: register the command with its endpoint differences, then classify
  // the line (absolute deltas, step signs, steep swap) on its way into the queue.
  // ---------------------------------------------------------------------------
  lrc_front #(
    .COORD_BITS (CB)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .opcode_i   (lrc_pkg::opcode_e'(s_axis_tuser)),
    .start_x_i  (s_axis_tdata[CB-1:0]),
    .start_y_i  (s_axis_tdata[2*CB-1:CB]),
    .end_x_i    (s_axis_tdata[3*CB-1:2*CB]),
    .end_y_i    (s_axis_tdata[4*CB-1:3*CB]),
    .push_o     (push),
    .entry_o    (wr_entry),
    .full_i     (full)
  );

  // Short command queue: lets the front keep accepting while the pixel side stalls.
  lrc_fifo #(
    .WIDTH (EntryW),
    .DEPTH (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (wr_entry),
    .full_o  (full),
    .pop_i   (pop),
    .rdata_o (rd_entry),
    .empty_o (empty)
  );

  // ---------------------------------------------------------------------------
  // Back end: start commands load the line state, step commands emit the current
  // pixel into the output register and advance the position and error term.
  // Steps with no line active drop out of the queue without a result.
  // ---------------------------------------------------------------------------
  lrc_back #(
    .COORD_BITS (CB)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .entry_i     (rd_entry),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .pixel_x_o   (pixel_x),
    .pixel_y_o   (pixel_y),
    .inside_o    (m_axis_tuser),
    .colour_o    (colour),
    .last_o      (m_axis_tlast)
  );

  // Pack the pixel payload; pad up to whole bytes with zeros.
  assign m_axis_tdata = MTdataW'({colour, pixel_y, pixel_x});

endmodule
